[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is held.
`define MRF_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define MRF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/mrf_pkg.sv]
// Types, constants and the CRC step function of the reply frame finder.
`default_nettype none

package mrf_pkg;

  localparam int unsigned CaptureBytes = 48;
  localparam int unsigned FrameLen     = 11;
  localparam int unsigned CountW       = $clog2(CaptureBytes + 1);
  localparam int unsigned CrcLen       = FrameLen - 2;
  localparam int unsigned CrcIdxW      = $clog2(CrcLen);
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);

  localparam logic [15:0] CrcInit           = 16'hFFFF;
  localparam logic [15:0] CrcPoly           = 16'hA001;
  localparam logic [7:0]  FuncReadHolding   = 8'h03;
  localparam logic [7:0]  ReadingByteCount  = 8'h06;

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_CLOSE = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data_in);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/modbus_read_response_finder.sv]
// Top level of the Modbus read-holding-registers reply frame finder.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    req_type, rx_byte
//   out      output     out_valid/out_ready  frame_found, three readings
//   cfg      input      cfg_we               cfg_wdata (device address)
//
// A byte item that does not complete a candidate frame is taken while the back end stays idle.
// A byte that completes a candidate starts a check: the CRC unit folds one frame byte
// per cycle over nine bytes, then a check state compares the header and CRC.
// A two-item queue lets input items be taken while the back end works or the result stalls.
// Reset clears the queue, the window count, the match flag and the result register.
`default_nettype none

module modbus_read_response_finder (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                req_type_i,
  input  wire  [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic               frame_found_o,
  output logic signed [15:0] temperature_centi_o,
  output logic [15:0]        moisture_centi_o,
  output logic [15:0]        conductivity_milli_o,
  input  wire                cfg_we_i,
  input  wire  [7:0]         cfg_wdata_i
);

  mrf_pkg::queue_head_t head;
  logic                 pop;

  mrf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .rx_byte_i  (rx_byte_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  mrf_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .head_i               (head),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .frame_found_o        (frame_found_o),
    .temperature_centi_o  (temperature_centi_o),
    .moisture_centi_o     (moisture_centi_o),
    .conductivity_milli_o (conductivity_milli_o)
  );

endmodule

`default_nettype wire

[hw/rtl/mrf_front.sv]
// Front end: accepts input items, classifies them and queues them for the back end.
`default_nettype none

module mrf_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire                 req_type_i,
  input  wire  [7:0]          rx_byte_i,
  input  wire                 pop_i,
  output mrf_pkg::queue_head_t head_o
);

  mrf_pkg::item_t                     entries_q [mrf_pkg::QueueDepth];
  logic [mrf_pkg::QueuePtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mrf_pkg::QueuePtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mrf_pkg::QueueCntW-1:0]      count_q, count_d;
  logic                               push;
  logic                               pop;
  mrf_pkg::item_t                     new_item;

  assign in_ready_o = (count_q != mrf_pkg::QueueCntW'(mrf_pkg::QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != '0);

  always_comb begin
    new_item.op   = req_type_i ? mrf_pkg::OP_CLOSE : mrf_pkg::OP_BYTE;
    new_item.data = rx_byte_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == mrf_pkg::QueuePtrW'(mrf_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == mrf_pkg::QueuePtrW'(mrf_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= new_item;
    end
  end

  always_comb begin
    head_o.valid = (count_q != '0);
    head_o.item  = entries_q[rd_ptr_q];
  end

endmodule

`default_nettype wire

[hw/rtl/mrf_back.sv]
// Back end: sliding byte window, sequential CRC check and result register.
`default_nettype none

module mrf_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [7:0]           cfg_wdata_i,
  input  mrf_pkg::queue_head_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic                 frame_found_o,
  output logic signed [15:0]   temperature_centi_o,
  output logic [15:0]          moisture_centi_o,
  output logic [15:0]          conductivity_milli_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_CHECK
  } state_e;

  state_e                         state_q;
  logic [7:0]                     win_q [mrf_pkg::FrameLen];
  logic [mrf_pkg::CountW-1:0]     count_q;
  logic [mrf_pkg::CountW-1:0]     count_inc;
  logic                           match_q;
  logic [47:0]                    held_q;
  logic [7:0]                     dev_addr_q;
  logic [15:0]                    crc_q;
  logic [mrf_pkg::CrcIdxW-1:0]    idx_q;
  logic                           out_valid_q;
  logic                           found_q;
  logic [47:0]                    readings_q;
  logic                           out_free;
  logic                           is_byte;
  logic                           kept;
  logic                           start_crc;
  logic                           pass;
  logic                           emit;

  assign out_free  = !out_valid_q || out_ready_i;
  assign is_byte   = (head_i.item.op == mrf_pkg::OP_BYTE);
  assign pop_o     = (state_q == ST_IDLE) && head_i.valid && (is_byte || out_free);
  assign emit      = pop_o && !is_byte;
  assign kept      = pop_o && is_byte &&
                     (count_q < mrf_pkg::CountW'(mrf_pkg::CaptureBytes));
  assign count_inc = count_q + 1'b1;
  assign start_crc = kept && !match_q &&
                     (count_inc >= mrf_pkg::CountW'(mrf_pkg::FrameLen));
  assign pass      = (win_q[0] == dev_addr_q) &&
                     (win_q[1] == mrf_pkg::FuncReadHolding) &&
                     (win_q[2] == mrf_pkg::ReadingByteCount) &&
                     (crc_q == {win_q[10], win_q[9]});

  always_ff @(posedge clk_i) begin
    if (kept) begin
      for (int i = 0; i < mrf_pkg::FrameLen - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[mrf_pkg::FrameLen-1] <= head_i.item.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      match_q     <= 1'b0;
      held_q      <= '0;
      dev_addr_q  <= 8'd1;
      crc_q       <= mrf_pkg::CrcInit;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      readings_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        dev_addr_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (is_byte) begin
              if (kept) begin
                count_q <= count_inc;
              end
              if (start_crc) begin
                state_q <= ST_CRC;
                crc_q   <= mrf_pkg::CrcInit;
                idx_q   <= '0;
              end
            end else begin
              found_q     <= match_q;
              readings_q  <= held_q;
              count_q     <= '0;
              match_q     <= 1'b0;
              held_q      <= '0;
            end
          end
        end
        ST_CRC: begin
          crc_q <= mrf_pkg::crc16_byte(crc_q, win_q[idx_q]);
          if (idx_q == mrf_pkg::CrcIdxW'(mrf_pkg::CrcLen - 1)) begin
            state_q <= ST_CHECK;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_CHECK: begin
          if (pass) begin
            match_q <= 1'b1;
            held_q  <= {win_q[3], win_q[4], win_q[5], win_q[6], win_q[7], win_q[8]};
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign frame_found_o        = found_q;
  assign temperature_centi_o  = signed'(readings_q[47:32]);
  assign moisture_centi_o     = readings_q[31:16];
  assign conductivity_milli_o = readings_q[15:0];

endmodule

`default_nettype wire

[hw/rtl/mrf_checker.sv]
// Port-level checker for the reply frame finder and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module mrf_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               out_valid_o,
  input wire               out_ready_i,
  input wire               frame_found_o,
  input wire signed [15:0] temperature_centi_o,
  input wire [15:0]        moisture_centi_o,
  input wire [15:0]        conductivity_milli_o
);

  logic        out_stall;
  logic        empty_result;
  logic        readings_zero;
  logic [48:0] out_payload;

  assign out_stall     = out_valid_o && !out_ready_i;
  assign empty_result  = out_valid_o && !frame_found_o;
  assign readings_zero = (temperature_centi_o == 16'sd0) && (moisture_centi_o == 16'd0) &&
                         (conductivity_milli_o == 16'd0);
  assign out_payload   = {frame_found_o, temperature_centi_o, moisture_centi_o,
                          conductivity_milli_o};

  `MRF_ASSERT(a_out_valid_holds, clk_i, rst_ni, out_stall |=> out_valid_o, "result item dropped")
  `MRF_ASSERT(a_payload_holds, clk_i, rst_ni, out_stall |=> $stable(out_payload), "result changed")
  `MRF_ASSERT(a_miss_zero, clk_i, rst_ni, empty_result |-> readings_zero, "readings on a miss")
  `MRF_ASSERT_ALWAYS(a_reset_clears_out, clk_i, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

bind modbus_read_response_finder mrf_checker u_mrf_checker (.*);

`default_nettype wire
